### rtl/psteu_pkg.sv
`timescale 1ns / 1ps

package psteu_pkg;

    localparam int SLOTS   = 32;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int LEN_W   = 6;
    localparam int OWNER_W = 8;
    localparam int PRIO_W  = 16;
    localparam int LEAF_W  = 8;
    localparam int TEX_W   = 8;
    localparam int CFG_W   = 8;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] CFG_SLOT_COUNT    = 2'd0;
    localparam logic [IDX_W-1:0] CFG_TEXTURE_SLOTS = 2'd1;
    localparam logic [IDX_W-1:0] CFG_MAX_LEAVES    = 2'd2;

    localparam logic [LEN_W-1:0]  SLOT_COUNT_RST    = 6'd32;
    localparam logic [TEX_W-1:0]  TEXTURE_SLOTS_RST = 8'd24;
    localparam logic [LEAF_W-1:0] MAX_LEAVES_RST    = 8'd8;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_LEAF   = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_FRAME  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CELL_NOP   = 2'd0,
        CELL_DROP  = 2'd1,
        CELL_INS   = 2'd2,
        CELL_CLEAR = 2'd3
    } cell_op_t;

    typedef struct packed {
        logic               valid;
        logic [SLOT_W-1:0]  slot;
        logic [OWNER_W-1:0] owner;
        logic [PRIO_W-1:0]  prio;
    } entry_t;

    typedef struct packed {
        cell_op_t           op;
        logic [SLOT_W-1:0]  drop_pos;
        logic [OWNER_W-1:0] key_owner;
        entry_t             ins;
    } cell_cmd_t;

endpackage

### rtl/psteu_cell.sv
`timescale 1ns / 1ps

module psteu_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [psteu_pkg::SLOT_W-1:0] cell_pos,
    input  psteu_pkg::cell_cmd_t       cmd,
    input  psteu_pkg::entry_t          left_entry,
    input  logic                       left_gt,
    input  psteu_pkg::entry_t          right_entry,
    output psteu_pkg::entry_t          entry,
    output logic                       gt,
    output logic                       match
);
    import psteu_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // Entry sorts after the new one: empty, or strictly larger number.
    assign gt    = !(entry_reg.valid && (entry_reg.prio <= cmd.ins.prio));
    assign match = entry_reg.valid && (entry_reg.owner == cmd.key_owner);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        case (cmd.op)
            CELL_DROP: begin
                if (cell_pos >= cmd.drop_pos) entry_next = right_entry;
            end
            CELL_INS: begin
                if (left_gt) begin
                    entry_next = left_entry;
                end else if (gt) begin
                    entry_next = cmd.ins;
                end
            end
            CELL_CLEAR: entry_next.valid = 1'b0;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
        end else begin
            entry_reg <= entry_next;
        end
    end

endmodule

### rtl/priority_slot_table_evict_unit.sv
`timescale 1ns / 1ps
// Flow: a lookup-only request passes FIND and DONE; a fresh add adds INS, a removal DROP; an
// eviction walks from the tail toward the head, then passes DROP and INS (straight to DONE if the
// walk refuses). A busy result side holds the result in DONE.
// Throughput: one request at a time; the next beat is taken in the cycle after the result is
// registered. The walk steps one list position per cycle through the cell chain.
// Reset (aresetn low, synchronous): empty list, no links, zero leaves, registers to defaults.

module priority_slot_table_evict_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [psteu_pkg::IDX_W-1:0]   cfg_index,
    input  logic [psteu_pkg::CFG_W-1:0]   cfg_wdata,
    // request stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,  // owner_id[7:0], priority_req[23:8],
                                                    // needs_texture[24], zero[31:25]
    input  logic [1:0]                    s_tuser,  // req_type[1:0]
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata   // accepted[0], slot_index[5:1],
                                                    // evicted_valid[6], evicted_owner[14:7],
                                                    // first_use[15]
);
    import psteu_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_FIND, ST_WALK, ST_DROP, ST_INS, ST_DONE
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [LEN_W-1:0]  slot_count_reg, slot_count_next;
    logic [TEX_W-1:0]  texture_slots_reg, texture_slots_next;
    logic [LEAF_W-1:0] max_leaves_reg, max_leaves_next;

    // request under work
    req_t               req_reg, req_next;
    logic [OWNER_W-1:0] owner_reg, owner_next;
    logic [PRIO_W-1:0]  pri_reg, pri_next;
    logic               tex_reg, tex_next;
    logic [SLOT_W-1:0]  pos_reg, pos_next;
    logic [SLOT_W-1:0]  new_slot_reg, new_slot_next;

    // table state
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  nfs_reg, nfs_next;
    logic [TEX_W-1:0]  tu_reg, tu_next;
    logic [LEAF_W-1:0] leaves_reg [SLOTS];
    logic [LEAF_W-1:0] leaves_next [SLOTS];
    logic [SLOTS-1:0]  linked_reg, linked_next;

    // pending result
    logic               acc_reg, acc_next;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic               evv_reg, evv_next;
    logic [OWNER_W-1:0] evo_reg, evo_next;
    logic               first_reg, first_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [15:0] m_data_reg, m_data_next;

    // cell chain
    cell_cmd_t        cmd;
    entry_t           cell_entry [SLOTS];
    entry_t           left_e [SLOTS];
    entry_t           right_e [SLOTS];
    logic [SLOTS-1:0] cell_gt;
    logic [SLOTS-1:0] left_gt;
    logic [SLOTS-1:0] cell_match;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign left_e[g]  = '0;
                assign left_gt[g] = 1'b0;
            end else begin : g_mid
                assign left_e[g]  = cell_entry[g-1];
                assign left_gt[g] = cell_gt[g-1];
            end
            if (g == SLOTS - 1) begin : g_tail
                assign right_e[g] = '0;
            end else begin : g_body
                assign right_e[g] = cell_entry[g+1];
            end
            psteu_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .cell_pos    (SLOT_W'(g)),
                .cmd         (cmd),
                .left_entry  (left_e[g]),
                .left_gt     (left_gt[g]),
                .right_entry (right_e[g]),
                .entry       (cell_entry[g]),
                .gt          (cell_gt[g]),
                .match       (cell_match[g])
            );
        end
    endgenerate

    // Broadcast one command per cycle to every cell.
    always_comb begin
        cmd.op        = CELL_NOP;
        cmd.drop_pos  = pos_reg;
        cmd.key_owner = owner_reg;
        cmd.ins.valid = 1'b1;
        cmd.ins.slot  = new_slot_reg;
        cmd.ins.owner = owner_reg;
        cmd.ins.prio  = pri_reg;
        case (state_reg)
            ST_FIND: if (req_reg == REQ_FRAME) cmd.op = CELL_CLEAR;
            ST_DROP: cmd.op = CELL_DROP;
            ST_INS:  cmd.op = CELL_INS;
            default: ;
        endcase
    end

    // Owner lookup: at most one cell matches.
    logic              found;
    logic [SLOT_W-1:0] cur_pos;
    logic [SLOT_W-1:0] cur_slot;

    always_comb begin
        cur_pos  = '0;
        cur_slot = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (cell_match[i]) begin
                cur_pos  = cur_pos | SLOT_W'(i);
                cur_slot = cur_slot | cell_entry[i].slot;
            end
        end
    end
    assign found = |cell_match;

    entry_t            pos_entry;
    logic [SLOT_W-1:0] leaf_addr;
    logic [LEAF_W-1:0] leaf_rd;
    logic [LEN_W-1:0]  cnt;
    logic              tex_free;
    logic              fresh_ok;

    assign pos_entry = cell_entry[pos_reg];
    assign leaf_addr = (state_reg == ST_WALK) ? pos_entry.slot : cur_slot;
    assign leaf_rd   = leaves_reg[leaf_addr];
    assign cnt       = (slot_count_reg > LEN_W'(SLOTS)) ? LEN_W'(SLOTS) : slot_count_reg;
    assign tex_free  = tu_reg < texture_slots_reg;
    assign fresh_ok  = (nfs_reg < cnt) && (!tex_reg || tex_free);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        state_next         = state_reg;
        slot_count_next    = slot_count_reg;
        texture_slots_next = texture_slots_reg;
        max_leaves_next    = max_leaves_reg;
        req_next           = req_reg;
        owner_next         = owner_reg;
        pri_next           = pri_reg;
        tex_next           = tex_reg;
        pos_next           = pos_reg;
        new_slot_next      = new_slot_reg;
        len_next           = len_reg;
        nfs_next           = nfs_reg;
        tu_next            = tu_reg;
        leaves_next        = leaves_reg;
        linked_next        = linked_reg;
        acc_next           = acc_reg;
        idx_next           = idx_reg;
        evv_next           = evv_reg;
        evo_next           = evo_reg;
        first_next         = first_reg;
        m_valid_next       = m_valid_reg;
        m_data_next        = m_data_reg;

        if (m_valid_reg && m_tready) m_valid_next = 1'b0;

        if (cfg_we) begin
            case (cfg_index)
                CFG_SLOT_COUNT:    slot_count_next    = cfg_wdata[LEN_W-1:0];
                CFG_TEXTURE_SLOTS: texture_slots_next = cfg_wdata[TEX_W-1:0];
                CFG_MAX_LEAVES:    max_leaves_next    = cfg_wdata[LEAF_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    req_next   = req_t'(s_tuser);
                    owner_next = s_tdata[7:0];
                    pri_next   = s_tdata[23:8];
                    tex_next   = s_tdata[24];
                    acc_next   = 1'b0;
                    idx_next   = '0;
                    evv_next   = 1'b0;
                    evo_next   = '0;
                    first_next = 1'b0;
                    state_next = ST_FIND;
                end
            end
            ST_FIND: begin
                state_next = ST_DONE;
                unique case (req_reg)
                    REQ_ADD: begin
                        if (found) begin
                            acc_next = 1'b1;
                            idx_next = cur_slot;
                        end else if (fresh_ok) begin
                            new_slot_next = nfs_reg[SLOT_W-1:0];
                            first_next    = (nfs_reg == '0);
                            nfs_next      = nfs_reg + LEN_W'(1);
                            if (tex_reg) tu_next = tu_reg + TEX_W'(1);
                            linked_next[nfs_reg[SLOT_W-1:0]] = 1'b1;
                            acc_next   = 1'b1;
                            idx_next   = nfs_reg[SLOT_W-1:0];
                            state_next = ST_INS;
                        end else if (len_reg != '0) begin
                            // no fresh slot: try the tail of the list
                            pos_next   = SLOT_W'(len_reg - LEN_W'(1));
                            state_next = ST_WALK;
                        end
                    end
                    REQ_LEAF: begin
                        if (found) begin
                            idx_next = cur_slot;
                            if (leaf_rd < max_leaves_reg) begin
                                leaves_next[cur_slot] = leaf_rd + LEAF_W'(1);
                                acc_next = 1'b1;
                            end
                        end
                    end
                    REQ_REMOVE: begin
                        if (found) begin
                            idx_next              = cur_slot;
                            acc_next              = 1'b1;
                            linked_next[cur_slot] = 1'b0;
                            pos_next              = cur_pos;
                            state_next            = ST_DROP;
                        end
                    end
                    REQ_FRAME: begin
                        // Clear leaves of listed slots only; removed slots keep theirs.
                        for (int i = 0; i < SLOTS; i++) begin
                            if (linked_reg[i]) leaves_next[i] = '0;
                        end
                        linked_next = '0;
                        len_next    = '0;
                        nfs_next    = '0;
                        tu_next     = '0;
                        acc_next    = 1'b1;
                    end
                    default: ;
                endcase
            end
            ST_WALK: begin
                if (pri_reg >= pos_entry.prio) begin
                    state_next = ST_DONE;
                end else if (tex_reg && !tex_free && (leaf_rd == '0)) begin
                    // step toward the head past a leafless entry
                    if (pos_reg == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        pos_next = pos_reg - SLOT_W'(1);
                    end
                end else begin
                    evv_next                    = 1'b1;
                    evo_next                    = pos_entry.owner;
                    leaves_next[pos_entry.slot] = '0;
                    new_slot_next               = pos_entry.slot;
                    acc_next                    = 1'b1;
                    idx_next                    = pos_entry.slot;
                    if (tex_reg && tex_free) tu_next = tu_reg + TEX_W'(1);
                    state_next = ST_DROP;
                end
            end
            ST_DROP: begin
                len_next   = len_reg - LEN_W'(1);
                state_next = (req_reg == REQ_ADD) ? ST_INS : ST_DONE;
            end
            ST_INS: begin
                len_next   = len_reg + LEN_W'(1);
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold the result until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {first_reg, evo_reg, evv_reg, idx_reg, acc_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            slot_count_reg    <= SLOT_COUNT_RST;
            texture_slots_reg <= TEXTURE_SLOTS_RST;
            max_leaves_reg    <= MAX_LEAVES_RST;
            len_reg           <= '0;
            nfs_reg           <= '0;
            tu_reg            <= '0;
            linked_reg        <= '0;
            m_valid_reg       <= 1'b0;
            for (int i = 0; i < SLOTS; i++) leaves_reg[i] <= '0;
        end else begin
            state_reg         <= state_next;
            slot_count_reg    <= slot_count_next;
            texture_slots_reg <= texture_slots_next;
            max_leaves_reg    <= max_leaves_next;
            len_reg           <= len_next;
            nfs_reg           <= nfs_next;
            tu_reg            <= tu_next;
            linked_reg        <= linked_next;
            m_valid_reg       <= m_valid_next;
            leaves_reg        <= leaves_next;
        end
        req_reg      <= req_next;
        owner_reg    <= owner_next;
        pri_reg      <= pri_next;
        tex_reg      <= tex_next;
        pos_reg      <= pos_next;
        new_slot_reg <= new_slot_next;
        acc_reg      <= acc_next;
        idx_reg      <= idx_next;
        evv_reg      <= evv_next;
        evo_reg      <= evo_next;
        first_reg    <= first_next;
        m_data_reg   <= m_data_next;
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import psteu_pkg::*;

    typedef struct {
        req_t        req;
        logic [7:0]  owner;
        logic [15:0] prio;
        logic        tex;
    } request_t;

    typedef struct {
        logic       acc;
        logic [4:0] idx;
        logic       evv;
        logic [7:0] evo;
        logic       first;
    } verdict_t;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 60;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_we = 1'b0;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [31:0]         s_tdata = '0;
    logic [1:0]          s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [15:0]         m_tdata;

    always #2 aclk = ~aclk;

    priority_slot_table_evict_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Shadow copy of the table, kept in step with every accepted request beat.
    logic [5:0]  shadow_slot_count = 6'd32;
    logic [7:0]  shadow_tex_slots  = 8'd24;
    logic [7:0]  shadow_max_leaves = 8'd8;
    logic [7:0]  tbl_owner   [SLOTS];
    logic        tbl_linked  [SLOTS];
    logic [15:0] tbl_prio    [SLOTS];
    logic [7:0]  tbl_leaves  [SLOTS];
    logic [4:0]  order_list  [SLOTS];
    int          order_len = 0;
    int          fresh_next = 0;
    int          tex_used = 0;

    request_t pending_reqs[$];
    verdict_t expected_verdicts[$];
    request_t cur_req;
    int       errors = 0;
    bit       calm = 0;       // phase without any idling
    int       send_gap = 0;
    int       recv_gap = 0;
    int       quiet_cycles = 0;

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            tbl_linked[i] = 1'b0;
            tbl_leaves[i] = 8'd0;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int lookup_owner(logic [7:0] who);
        for (int i = 0; i < SLOTS; i++)
            if (tbl_linked[i] && tbl_owner[i] == who) return i;
        return -1;
    endfunction

    task automatic unlink_from_order(int slot);
        for (int i = 0; i < order_len; i++) begin
            if (order_list[i] == slot) begin
                for (int j = i; j + 1 < order_len; j++) order_list[j] = order_list[j + 1];
                order_len--;
                return;
            end
        end
    endtask

    task automatic insert_by_prio(int slot);
        int pos;
        pos = 0;
        if (order_len >= SLOTS) return;
        // equal priorities stay ahead of the newcomer
        while (pos < order_len && tbl_prio[order_list[pos]] <= tbl_prio[slot]) pos++;
        for (int j = order_len; j > pos; j--) order_list[j] = order_list[j - 1];
        order_list[pos] = slot[4:0];
        order_len++;
    endtask

    task automatic resolve_request(request_t rq, output verdict_t v);
        int  cur, cnt, s, pos;
        bit  ok;
        v = '{1'b0, 5'd0, 1'b0, 8'd0, 1'b0};
        cur = lookup_owner(rq.owner);
        case (rq.req)
            REQ_ADD: begin
                if (cur >= 0) begin
                    v.acc = 1'b1;
                    v.idx = cur[4:0];
                end else begin
                    cnt = (shadow_slot_count > SLOTS) ? SLOTS : shadow_slot_count;
                    s = 0;
                    ok = 1;
                    if (fresh_next < cnt && (!rq.tex || tex_used < shadow_tex_slots)) begin
                        s = fresh_next;
                        v.first = (fresh_next == 0);
                        fresh_next++;
                        if (rq.tex) tex_used++;
                    end else if (order_len == 0) begin
                        ok = 0;
                    end else begin
                        pos = order_len - 1;
                        s = order_list[pos];
                        if (rq.prio >= tbl_prio[s]) begin
                            ok = 0;
                        end else if (rq.tex) begin
                            if (tex_used >= shadow_tex_slots) begin
                                // walk toward the head past leafless entries
                                while (ok && tbl_leaves[s] == 0) begin
                                    if (pos == 0) begin
                                        ok = 0;
                                    end else begin
                                        pos--;
                                        s = order_list[pos];
                                        if (rq.prio >= tbl_prio[s]) ok = 0;
                                    end
                                end
                            end else begin
                                tex_used++;
                            end
                        end
                        if (ok) begin
                            v.evv = 1'b1;
                            v.evo = tbl_owner[s];
                            tbl_leaves[s] = 8'd0;
                            tbl_linked[s] = 1'b0;
                            unlink_from_order(s);
                        end
                    end
                    if (ok) begin
                        tbl_owner[s]  = rq.owner;
                        tbl_linked[s] = 1'b1;
                        tbl_prio[s]   = rq.prio;
                        insert_by_prio(s);
                        v.acc = 1'b1;
                        v.idx = s[4:0];
                    end else begin
                        v.first = 1'b0;
                    end
                end
            end
            REQ_LEAF: begin
                if (cur >= 0) begin
                    v.idx = cur[4:0];
                    if (tbl_leaves[cur] < shadow_max_leaves) begin
                        tbl_leaves[cur] = tbl_leaves[cur] + 8'd1;
                        v.acc = 1'b1;
                    end
                end
            end
            REQ_REMOVE: begin
                if (cur >= 0) begin
                    v.idx = cur[4:0];
                    v.acc = 1'b1;
                    tbl_linked[cur] = 1'b0;
                    unlink_from_order(cur);
                end
            end
            default: begin
                for (int i = 0; i < order_len; i++) begin
                    tbl_leaves[order_list[i]] = 8'd0;
                    tbl_linked[order_list[i]] = 1'b0;
                end
                order_len = 0;
                fresh_next = 0;
                tex_used = 0;
                v.acc = 1'b1;
            end
        endcase
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Driver: present queued request beats, hold each until taken.
    always @(posedge aclk) begin
        bit       busy;
        verdict_t v;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            busy = s_tvalid;
            if (s_tvalid && s_tready) begin
                resolve_request(cur_req, v);
                expected_verdicts.push_back(v);
                busy = 0;
            end
            if (!busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    s_tdata <= {7'd0, cur_req.tex, cur_req.prio, cur_req.owner};
                    s_tuser <= cur_req.req;
                    s_tvalid <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result beat against the oldest expectation.
    always @(posedge aclk) begin
        verdict_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch("unexpected beat", m_tdata, 0);
            end else begin
                w = expected_verdicts.pop_front();
                if (m_tdata[0] !== w.acc) report_mismatch("accepted", m_tdata[0], w.acc);
                if (m_tdata[5:1] !== w.idx) report_mismatch("slot_index", m_tdata[5:1], w.idx);
                if (m_tdata[6] !== w.evv) report_mismatch("evicted_valid", m_tdata[6], w.evv);
                if (m_tdata[14:7] !== w.evo)
                    report_mismatch("evicted_owner", m_tdata[14:7], w.evo);
                if (m_tdata[15] !== w.first) report_mismatch("first_use", m_tdata[15], w.first);
            end
        end
        // stall the result side in random bursts
        if (recv_gap > 0) begin
            recv_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            recv_gap = pick_gap();
        end
    end

    // Watchdog: end the run if no beat moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired at %0t", $realtime);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [7:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_SLOT_COUNT:    shadow_slot_count = val[5:0];
            CFG_TEXTURE_SLOTS: shadow_tex_slots = val;
            default:           shadow_max_leaves = val;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(logic [7:0] cnt, logic [7:0] tex, logic [7:0] leaves);
        write_reg(CFG_SLOT_COUNT, cnt);
        write_reg(CFG_TEXTURE_SLOTS, tex);
        write_reg(CFG_MAX_LEAVES, leaves);
    endtask

    task automatic queue_req(req_t r, logic [7:0] o, logic [15:0] p, logic t);
        request_t rq;
        rq.req = r;
        rq.owner = o;
        rq.prio = p;
        rq.tex = t;
        pending_reqs.push_back(rq);
    endtask

    // Drain: wait for every result, then let the block settle.
    task automatic drain();
        do begin
            @(posedge aclk);
            #1;
        end while (pending_reqs.size() > 0 || s_tvalid || expected_verdicts.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_random(int n);
        int r;
        req_t k;
        logic [7:0]  o;
        logic [15:0] p;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            k = (r < 50) ? REQ_ADD : (r < 75) ? REQ_LEAF : (r < 94) ? REQ_REMOVE : REQ_FRAME;
            // a small pool of owners keeps links and leaves in play
            o = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 15)) : 8'($urandom);
            p = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 15)) : 16'($urandom);
            queue_req(k, o, p, 1'($urandom));
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: defaults, extremes of fields, linked owner, leaves, removal, frame reset
        queue_req(REQ_ADD, 8'd0, 16'd0, 1'b0);
        queue_req(REQ_ADD, 8'd255, 16'hFFFF, 1'b1);
        queue_req(REQ_ADD, 8'd0, 16'd7, 1'b0);
        queue_req(REQ_LEAF, 8'd255, 16'd0, 1'b0);
        queue_req(REQ_LEAF, 8'd9, 16'd0, 1'b0);
        queue_req(REQ_REMOVE, 8'd0, 16'd0, 1'b0);
        queue_req(REQ_REMOVE, 8'd0, 16'd0, 1'b0);
        queue_req(REQ_ADD, 8'd0, 16'd3, 1'b1);
        queue_req(REQ_FRAME, 8'd170, 16'hAAAA, 1'b1);
        queue_req(REQ_ADD, 8'd85, 16'h5555, 1'b0);
        drain();

        // no slots at all: add with an empty list is refused
        configure(8'd0, 8'd0, 8'd0);
        queue_req(REQ_FRAME, 8'd0, 16'd0, 1'b0);
        queue_req(REQ_ADD, 8'd1, 16'd1, 1'b0);
        queue_req(REQ_LEAF, 8'd1, 16'd0, 1'b0);
        drain();

        // two slots, no textures: walk runs off the head, then finds a leafy victim
        configure(8'd2, 8'd0, 8'd1);
        queue_req(REQ_FRAME, 8'd0, 16'd0, 1'b0);
        queue_req(REQ_ADD, 8'd1, 16'd100, 1'b0);
        queue_req(REQ_ADD, 8'd2, 16'd200, 1'b0);
        queue_req(REQ_ADD, 8'd3, 16'd50, 1'b1);
        queue_req(REQ_LEAF, 8'd1, 16'd0, 1'b0);
        queue_req(REQ_LEAF, 8'd1, 16'd0, 1'b0);
        queue_req(REQ_ADD, 8'd3, 16'd50, 1'b1);
        queue_req(REQ_ADD, 8'd4, 16'd300, 1'b0);
        queue_req(REQ_ADD, 8'd5, 16'd10, 1'b0);
        drain();

        // random phases across a spread of register settings
        for (int ph = 0; ph < 8; ph++) begin
            calm = (ph % 3 == 2);
            case (ph)
                0: configure(8'd32, 8'd24, 8'd8);
                1: configure(8'd255, 8'd255, 8'd255);
                2: configure(8'd4, 8'd2, 8'd1);
                3: configure(8'd8, 8'd0, 8'd0);
                4: configure(8'd1, 8'd255, 8'd3);
                5: configure(8'd63, 8'd5, 8'd2);
                default: configure(8'($urandom), 8'($urandom_range(0, 40)),
                                   8'($urandom_range(0, 10)));
            endcase
            queue_req(REQ_FRAME, 8'd0, 16'd0, 1'b0);
            queue_random(78);
            drain();
        end

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
